// ----- rtl/vsq_pkg.sv -----
package vsq_pkg;

  localparam int CoordW   = 32;
  localparam int SumW     = CoordW + 1;
  localparam int MagW     = 32;
  localparam int ResW     = 9;
  localparam int ExtentW  = 31;
  localparam int ScaleW   = 40;
  localparam int ScaleLoW = 20;
  localparam int ScaleHiW = ScaleW - ScaleLoW;
  localparam int InvW     = 32;
  localparam int DensW    = 32;
  localparam int CompW    = 16;
  localparam int IndexW   = 24;
  localparam int ByteW    = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = ScaleW;

  // axis products and the Q48 truncation point
  localparam int AxProdW  = MagW + ScaleHiW;
  localparam int AxSumW   = AxProdW + 1;
  localparam int QShift   = 28;
  localparam int QW       = AxSumW - QShift;

  localparam int DensProdW  = DensW - 1 + InvW;
  localparam int CompProdW  = CompW - 1 + ByteW;
  localparam int CompShift  = 14;
  localparam int RowW       = 2 * ResW;
  localparam int IdxProdW   = RowW + ResW;

  localparam logic [ByteW-1:0] BYTE_MAX = 8'd255;

  localparam logic [ResW-1:0]     RES_RESET   = 9'd256;
  localparam logic [ExtentW-1:0]  EXTENT_RESET = 31'd65536;
  localparam logic [ScaleW-1:0]   SCALE_RESET = 40'h80_0000_0000;
  localparam logic [InvW-1:0]     INV_RESET   = 32'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RESOLUTION      = 2'd0,
    CFG_EXTENT          = 2'd1,
    CFG_GRID_SCALE      = 2'd2,
    CFG_INV_MAX_DENSITY = 2'd3
  } vsq_cfg_idx_t;

  typedef struct packed {
    logic [ResW-1:0]    resolution;
    logic [ExtentW-1:0] extent;
    logic [ScaleW-1:0]  grid_scale;
    logic [InvW-1:0]    inv_max_density;
  } vsq_cfg_t;

  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } vsq_axis_t;

  typedef struct packed {
    vsq_axis_t               ax_x;
    vsq_axis_t               ax_y;
    vsq_axis_t               ax_z;
    logic signed [DensW-1:0] density;
    logic signed [CompW-1:0] comp_b;
    logic signed [CompW-1:0] comp_g;
    logic signed [CompW-1:0] comp_r;
  } vsq_entry_t;

endpackage

// ----- rtl/vsq_front.sv -----
module vsq_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [vsq_pkg::ExtentW-1:0]     extent,
  input  logic                            start,
  output logic                            busy,
  input  logic                            node_valid,
  input  logic signed [vsq_pkg::CoordW-1:0] center_x,
  input  logic signed [vsq_pkg::CoordW-1:0] center_y,
  input  logic signed [vsq_pkg::CoordW-1:0] center_z,
  input  logic signed [vsq_pkg::DensW-1:0]  density,
  input  logic signed [vsq_pkg::CompW-1:0]  comp_b,
  input  logic signed [vsq_pkg::CompW-1:0]  comp_g,
  input  logic signed [vsq_pkg::CompW-1:0]  comp_r,
  input  logic                            q_full,
  output logic                            push,
  output vsq_pkg::vsq_entry_t             entry
);

  logic                              f_valid;
  logic                              f_valid_next;
  logic signed [vsq_pkg::SumW-1:0]   f_sum_x;
  logic signed [vsq_pkg::SumW-1:0]   f_sum_y;
  logic signed [vsq_pkg::SumW-1:0]   f_sum_z;
  logic signed [vsq_pkg::DensW-1:0]  f_density;
  logic signed [vsq_pkg::CompW-1:0]  f_comp_b;
  logic signed [vsq_pkg::CompW-1:0]  f_comp_g;
  logic signed [vsq_pkg::CompW-1:0]  f_comp_r;
  logic signed [vsq_pkg::SumW-1:0]   ext_s;
  logic                              accept;
  logic                              take;

  function automatic vsq_pkg::vsq_axis_t to_axis(logic signed [vsq_pkg::SumW-1:0] s);
    vsq_pkg::vsq_axis_t a;
    a.neg = s[vsq_pkg::SumW-1];
    a.mag = a.neg ? vsq_pkg::MagW'(-s) : s[vsq_pkg::MagW-1:0];
    return a;
  endfunction

  assign busy   = f_valid && q_full;
  assign accept = start && !busy;
  // invalid nodes are dropped here and never reach the queue
  assign take   = accept && node_valid;
  assign push   = f_valid && !q_full;
  assign ext_s  = $signed({2'b00, extent});

  always_comb begin
    f_valid_next = f_valid;
    if (take) begin
      f_valid_next = 1'b1;
    end else if (push) begin
      f_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_sum_x   <= $signed({center_x[vsq_pkg::CoordW-1], center_x}) + ext_s;
      f_sum_y   <= $signed({center_y[vsq_pkg::CoordW-1], center_y}) + ext_s;
      f_sum_z   <= $signed({center_z[vsq_pkg::CoordW-1], center_z}) + ext_s;
      f_density <= density;
      f_comp_b  <= comp_b;
      f_comp_g  <= comp_g;
      f_comp_r  <= comp_r;
    end
  end

  always_comb begin
    entry.ax_x    = to_axis(f_sum_x);
    entry.ax_y    = to_axis(f_sum_y);
    entry.ax_z    = to_axis(f_sum_z);
    entry.density = f_density;
    entry.comp_b  = f_comp_b;
    entry.comp_g  = f_comp_g;
    entry.comp_r  = f_comp_r;
  end

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (f_valid && !q_full && !(start && node_valid)) |=> !f_valid)
    else $error("front stage kept a request that was already pushed");

endmodule

// ----- rtl/vsq_queue.sv -----
module vsq_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  vsq_pkg::vsq_entry_t wr_data,
  output logic                full,
  input  logic                pop,
  output logic                rd_valid,
  output vsq_pkg::vsq_entry_t rd_data
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  vsq_pkg::vsq_entry_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic            do_pop;

  assign full     = (count == FullCnt);
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_pop   = pop && rd_valid;

  always_comb begin
    count_next = count;
    if (push && !do_pop) begin
      count_next = count + CntW'(1);
    end else if (do_pop && !push) begin
      count_next = count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !do_pop) |=> count == $past(count) + CntW'(1))
    else $error("queue count lost a push");

endmodule

// ----- rtl/vsq_back.sv -----
module vsq_back (
  input  logic                           clk,
  input  logic                           rst,
  input  vsq_pkg::vsq_cfg_t              cfg,
  input  logic                           rd_valid,
  input  vsq_pkg::vsq_entry_t            rd_data,
  output logic                           pop,
  output logic                           done,
  output logic [vsq_pkg::IndexW-1:0]     voxel_index,
  output logic [vsq_pkg::ByteW-1:0]      blue_byte,
  output logic [vsq_pkg::ByteW-1:0]      green_byte,
  output logic [vsq_pkg::ByteW-1:0]      red_byte,
  output logic [vsq_pkg::ByteW-1:0]      alpha_byte
);

  localparam int NAx = 3;

  vsq_pkg::vsq_axis_t              ax [NAx];
  logic [vsq_pkg::ScaleHiW-1:0]    sc_hi;
  logic [vsq_pkg::ScaleLoW-1:0]    sc_lo;
  logic                            d_pos;

  // stage 1: raw products
  logic                            s1_valid;
  logic [vsq_pkg::AxProdW-1:0]     s1_a   [NAx];
  logic [vsq_pkg::AxProdW-1:0]     s1_b   [NAx];
  logic                            s1_neg [NAx];
  logic [vsq_pkg::DensProdW-1:0]   s1_p;
  logic [vsq_pkg::CompProdW-1:0]   s1_cb;
  logic [vsq_pkg::CompProdW-1:0]   s1_cg;
  logic [vsq_pkg::CompProdW-1:0]   s1_cr;

  // stage 2: voxel coords, range check, clamped colors
  logic [vsq_pkg::AxSumW-1:0]      ax_sum [NAx];
  logic [vsq_pkg::QW-1:0]          q      [NAx];
  logic [NAx-1:0]                  in_range;
  logic                            s2_valid;
  logic [vsq_pkg::ResW-1:0]        s2_x;
  logic [vsq_pkg::ResW-1:0]        s2_y;
  logic [vsq_pkg::ResW-1:0]        s2_z;
  logic                            s2_sat;
  logic [vsq_pkg::InvW-1:0]        s2_plow;
  logic [vsq_pkg::ByteW-1:0]       s2_b;
  logic [vsq_pkg::ByteW-1:0]       s2_g;
  logic [vsq_pkg::ByteW-1:0]       s2_r;

  // stage 3: row index and alpha
  logic [vsq_pkg::InvW+vsq_pkg::ByteW-1:0] p255;
  logic                            s3_valid;
  logic [vsq_pkg::RowW-1:0]        s3_zr;
  logic [vsq_pkg::ResW-1:0]        s3_x;
  logic [vsq_pkg::ByteW-1:0]       s3_a;
  logic [vsq_pkg::ByteW-1:0]       s3_b;
  logic [vsq_pkg::ByteW-1:0]       s3_g;
  logic [vsq_pkg::ByteW-1:0]       s3_r;

  logic [vsq_pkg::IdxProdW-1:0]    idx_full;

  function automatic logic [vsq_pkg::CompProdW-1:0] comp_prod(
    logic signed [vsq_pkg::CompW-1:0] c);
    logic [vsq_pkg::CompProdW-1:0] p;
    p = c[vsq_pkg::CompW-1] ? '0
        : vsq_pkg::CompProdW'(c[vsq_pkg::CompW-2:0]) *
          vsq_pkg::CompProdW'(vsq_pkg::BYTE_MAX);
    return p;
  endfunction

  function automatic logic [vsq_pkg::ByteW-1:0] comp_clamp(
    logic [vsq_pkg::CompProdW-1:0] p);
    logic [vsq_pkg::CompProdW-vsq_pkg::CompShift-1:0] v;
    v = p[vsq_pkg::CompProdW-1:vsq_pkg::CompShift];
    return v[vsq_pkg::CompProdW-vsq_pkg::CompShift-1] ? vsq_pkg::BYTE_MAX
           : v[vsq_pkg::ByteW-1:0];
  endfunction

  assign pop   = rd_valid;
  assign ax[0] = rd_data.ax_x;
  assign ax[1] = rd_data.ax_y;
  assign ax[2] = rd_data.ax_z;
  assign sc_hi = cfg.grid_scale[vsq_pkg::ScaleW-1:vsq_pkg::ScaleLoW];
  assign sc_lo = cfg.grid_scale[vsq_pkg::ScaleLoW-1:0];
  assign d_pos = !rd_data.density[vsq_pkg::DensW-1] && (rd_data.density != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= pop;
      s2_valid <= s1_valid && (&in_range);
      s3_valid <= s2_valid;
      done     <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NAx; i++) begin
      s1_a[i]   <= vsq_pkg::AxProdW'(ax[i].mag) * vsq_pkg::AxProdW'(sc_hi);
      s1_b[i]   <= vsq_pkg::AxProdW'(ax[i].mag) * vsq_pkg::AxProdW'(sc_lo);
      s1_neg[i] <= ax[i].neg;
    end
    // zero reciprocal or non-positive density forces alpha to zero
    s1_p  <= (d_pos && cfg.inv_max_density != '0)
             ? vsq_pkg::DensProdW'(rd_data.density[vsq_pkg::DensW-2:0]) *
               vsq_pkg::DensProdW'(cfg.inv_max_density)
             : '0;
    s1_cb <= comp_prod(rd_data.comp_b);
    s1_cg <= comp_prod(rd_data.comp_g);
    s1_cr <= comp_prod(rd_data.comp_r);
  end

  always_comb begin
    for (int i = 0; i < NAx; i++) begin
      ax_sum[i]   = vsq_pkg::AxSumW'(s1_a[i]) +
                    vsq_pkg::AxSumW'(s1_b[i][vsq_pkg::AxProdW-1:vsq_pkg::ScaleLoW]);
      q[i]        = ax_sum[i][vsq_pkg::AxSumW-1:vsq_pkg::QShift];
      // small negative sums truncate to voxel 0 and stay in
      in_range[i] = !(s1_neg[i] && q[i] != '0) &&
                    (q[i] < vsq_pkg::QW'(cfg.resolution));
    end
  end

  always_ff @(posedge clk) begin
    s2_x    <= q[0][vsq_pkg::ResW-1:0];
    s2_y    <= q[1][vsq_pkg::ResW-1:0];
    s2_z    <= q[2][vsq_pkg::ResW-1:0];
    s2_sat  <= |s1_p[vsq_pkg::DensProdW-1:vsq_pkg::InvW];
    s2_plow <= s1_p[vsq_pkg::InvW-1:0];
    s2_b    <= comp_clamp(s1_cb);
    s2_g    <= comp_clamp(s1_cg);
    s2_r    <= comp_clamp(s1_cr);
  end

  // p*255 as (p<<8) - p
  assign p255 = {s2_plow, {vsq_pkg::ByteW{1'b0}}} -
                {{vsq_pkg::ByteW{1'b0}}, s2_plow};

  always_ff @(posedge clk) begin
    s3_zr <= vsq_pkg::RowW'(s2_z) * vsq_pkg::RowW'(cfg.resolution) +
             vsq_pkg::RowW'(s2_y);
    s3_x  <= s2_x;
    s3_a  <= s2_sat ? vsq_pkg::BYTE_MAX
             : p255[vsq_pkg::InvW+vsq_pkg::ByteW-1:vsq_pkg::InvW];
    s3_b  <= s2_b;
    s3_g  <= s2_g;
    s3_r  <= s2_r;
  end

  assign idx_full = vsq_pkg::IdxProdW'(s3_zr) * vsq_pkg::IdxProdW'(cfg.resolution) +
                    vsq_pkg::IdxProdW'(s3_x);

  always_ff @(posedge clk) begin
    voxel_index <= idx_full[vsq_pkg::IndexW-1:0];
    blue_byte   <= s3_b;
    green_byte  <= s3_g;
    red_byte    <= s3_r;
    alpha_byte  <= s3_a;
  end

  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(pop, 4))
    else $error("result strobe without a popped request");

endmodule

// ----- rtl/voxel_splat_quantizer.sv -----
// channel   | handshake               | payload
// ----------+-------------------------+----------------------------------------------
// request   | start / busy            | node_valid, center_x/y/z, density, comp_b/g/r
// result    | done (1-cycle strobe)   | voxel_index, blue/green/red/alpha_byte
// config    | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One request per cycle sustained while busy is low.
// Path: front register, queue slot, three back stages, output register.
// Invalid or out-of-cube nodes produce no strobe.
// busy rises only while the front register holds a request and the queue is full.
// rst is synchronous and clears the config to its defaults and empties the pipe.
module voxel_splat_quantizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                node_valid,
  input  logic signed [vsq_pkg::CoordW-1:0]   center_x,
  input  logic signed [vsq_pkg::CoordW-1:0]   center_y,
  input  logic signed [vsq_pkg::CoordW-1:0]   center_z,
  input  logic signed [vsq_pkg::DensW-1:0]    density,
  input  logic signed [vsq_pkg::CompW-1:0]    comp_b,
  input  logic signed [vsq_pkg::CompW-1:0]    comp_g,
  input  logic signed [vsq_pkg::CompW-1:0]    comp_r,
  output logic                                done,
  output logic [vsq_pkg::IndexW-1:0]          voxel_index,
  output logic [vsq_pkg::ByteW-1:0]           blue_byte,
  output logic [vsq_pkg::ByteW-1:0]           green_byte,
  output logic [vsq_pkg::ByteW-1:0]           red_byte,
  output logic [vsq_pkg::ByteW-1:0]           alpha_byte,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vsq_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [vsq_pkg::CfgDataW-1:0]        cfg_data
);

  vsq_pkg::vsq_cfg_t   cfg;
  vsq_pkg::vsq_entry_t q_wr;
  vsq_pkg::vsq_entry_t q_rd;
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.resolution      <= vsq_pkg::RES_RESET;
      cfg.extent          <= vsq_pkg::EXTENT_RESET;
      cfg.grid_scale      <= vsq_pkg::SCALE_RESET;
      cfg.inv_max_density <= vsq_pkg::INV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (vsq_pkg::vsq_cfg_idx_t'(cfg_index))
        vsq_pkg::CFG_RESOLUTION: begin
          cfg.resolution <= cfg_data[vsq_pkg::ResW-1:0];
        end
        vsq_pkg::CFG_EXTENT: begin
          cfg.extent <= cfg_data[vsq_pkg::ExtentW-1:0];
        end
        vsq_pkg::CFG_GRID_SCALE: begin
          cfg.grid_scale <= cfg_data[vsq_pkg::ScaleW-1:0];
        end
        vsq_pkg::CFG_INV_MAX_DENSITY: begin
          cfg.inv_max_density <= cfg_data[vsq_pkg::InvW-1:0];
        end
      endcase
    end
  end

  vsq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .extent     (cfg.extent),
    .start      (start),
    .busy       (busy),
    .node_valid (node_valid),
    .center_x   (center_x),
    .center_y   (center_y),
    .center_z   (center_z),
    .density    (density),
    .comp_b     (comp_b),
    .comp_g     (comp_g),
    .comp_r     (comp_r),
    .q_full     (q_full),
    .push       (q_push),
    .entry      (q_wr)
  );

  vsq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_data  (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rd)
  );

  vsq_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .rd_valid    (q_valid),
    .rd_data     (q_rd),
    .pop         (q_pop),
    .done        (done),
    .voxel_index (voxel_index),
    .blue_byte   (blue_byte),
    .green_byte  (green_byte),
    .red_byte    (red_byte),
    .alpha_byte  (alpha_byte)
  );

endmodule

// ----- tb/voxel_splat_quantizer_tb.sv -----
module voxel_splat_quantizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic                              node_valid;
    logic signed [vsq_pkg::CoordW-1:0] center_x;
    logic signed [vsq_pkg::CoordW-1:0] center_y;
    logic signed [vsq_pkg::CoordW-1:0] center_z;
    logic signed [vsq_pkg::DensW-1:0]  density;
    logic signed [vsq_pkg::CompW-1:0]  comp_b;
    logic signed [vsq_pkg::CompW-1:0]  comp_g;
    logic signed [vsq_pkg::CompW-1:0]  comp_r;
  } node_t;

  typedef struct packed {
    logic [vsq_pkg::IndexW-1:0] voxel_index;
    logic [vsq_pkg::ByteW-1:0]  blue_byte;
    logic [vsq_pkg::ByteW-1:0]  green_byte;
    logic [vsq_pkg::ByteW-1:0]  red_byte;
    logic [vsq_pkg::ByteW-1:0]  alpha_byte;
  } voxel_word_t;

  // one line of the directed table: a register write or a node
  typedef struct {
    bit                           is_write;
    vsq_pkg::vsq_cfg_idx_t        write_idx;
    logic [vsq_pkg::CfgDataW-1:0] write_val;
    node_t                        node;
    bit                           typed;
    bit                           typed_hit;
    voxel_word_t                  typed_word;
  } dir_row_t;

  localparam int     ONE_Q16 = 65536;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic node_valid;
  logic signed [vsq_pkg::CoordW-1:0] center_x;
  logic signed [vsq_pkg::CoordW-1:0] center_y;
  logic signed [vsq_pkg::CoordW-1:0] center_z;
  logic signed [vsq_pkg::DensW-1:0]  density;
  logic signed [vsq_pkg::CompW-1:0]  comp_b;
  logic signed [vsq_pkg::CompW-1:0]  comp_g;
  logic signed [vsq_pkg::CompW-1:0]  comp_r;
  logic done;
  logic [vsq_pkg::IndexW-1:0] voxel_index;
  logic [vsq_pkg::ByteW-1:0]  blue_byte;
  logic [vsq_pkg::ByteW-1:0]  green_byte;
  logic [vsq_pkg::ByteW-1:0]  red_byte;
  logic [vsq_pkg::ByteW-1:0]  alpha_byte;
  logic cfg_valid;
  logic cfg_ready;
  logic [vsq_pkg::CfgIdxW-1:0]  cfg_index;
  logic [vsq_pkg::CfgDataW-1:0] cfg_data;

  vsq_pkg::vsq_cfg_t grid_cfg;
  voxel_word_t       voxel_expect[$];
  int                mismatch_cnt = 0;
  int                burst_left = 0;

  voxel_splat_quantizer dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .node_valid  (node_valid),
    .center_x    (center_x),
    .center_y    (center_y),
    .center_z    (center_z),
    .density     (density),
    .comp_b      (comp_b),
    .comp_g      (comp_g),
    .comp_r      (comp_r),
    .done        (done),
    .voxel_index (voxel_index),
    .blue_byte   (blue_byte),
    .green_byte  (green_byte),
    .red_byte    (red_byte),
    .alpha_byte  (alpha_byte),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit axis_voxel(input logic signed [vsq_pkg::CoordW-1:0] c,
                                    output u64_t q);
    longint sum;
    u64_t   mag;
    u64_t   hi;
    u64_t   lo;
    sum = longint'(c) + longint'(grid_cfg.extent);
    mag = (sum < 0) ? -sum : sum;
    // split the Q8.32 scale so the Q48 product fits in 64 bits
    hi = u64_t'(grid_cfg.grid_scale >> vsq_pkg::ScaleLoW);
    lo = u64_t'(grid_cfg.grid_scale[vsq_pkg::ScaleLoW-1:0]);
    q = (mag * hi + ((mag * lo) >> vsq_pkg::ScaleLoW)) >> vsq_pkg::QShift;
    if (sum < 0 && q != 0) return 1'b0;
    return q < u64_t'(grid_cfg.resolution);
  endfunction

  function automatic logic [vsq_pkg::ByteW-1:0] color_level(
    logic signed [vsq_pkg::CompW-1:0] c);
    int v;
    if (c <= 0) return '0;
    v = (int'(c) * 255) >>> vsq_pkg::CompShift;
    return (v > 255) ? vsq_pkg::BYTE_MAX : v[vsq_pkg::ByteW-1:0];
  endfunction

  function automatic logic [vsq_pkg::ByteW-1:0] alpha_level(
    logic signed [vsq_pkg::DensW-1:0] d);
    u64_t p;
    if (grid_cfg.inv_max_density == '0 || d <= 0) return '0;
    p = u64_t'(d) * u64_t'(grid_cfg.inv_max_density);
    if (p >= 64'h1_0000_0000) return vsq_pkg::BYTE_MAX;
    p = (p * 255) >> 32;
    return p[vsq_pkg::ByteW-1:0];
  endfunction

  function automatic bit splat_node(input node_t n, output voxel_word_t w);
    u64_t x;
    u64_t y;
    u64_t z;
    u64_t idx;
    w = '0;
    if (!n.node_valid) return 1'b0;
    if (!axis_voxel(n.center_x, x) || !axis_voxel(n.center_y, y) ||
        !axis_voxel(n.center_z, z)) return 1'b0;
    idx = (z * u64_t'(grid_cfg.resolution) + y) * u64_t'(grid_cfg.resolution) + x;
    w.voxel_index = idx[vsq_pkg::IndexW-1:0];
    w.blue_byte   = color_level(n.comp_b);
    w.green_byte  = color_level(n.comp_g);
    w.red_byte    = color_level(n.comp_r);
    w.alpha_byte  = alpha_level(n.density);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_bad(string what, voxel_word_t want, voxel_word_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t %s: want idx=%h b=%0d g=%0d r=%0d a=%0d, got idx=%h b=%0d g=%0d r=%0d a=%0d",
               $realtime, what, want.voxel_index, want.blue_byte, want.green_byte,
               want.red_byte, want.alpha_byte, got.voxel_index, got.blue_byte,
               got.green_byte, got.red_byte, got.alpha_byte);
    end
  endtask

  always @(posedge clk) begin : result_check
    voxel_word_t got;
    voxel_word_t want;
    if (!rst && done) begin
      got = {voxel_index, blue_byte, green_byte, red_byte, alpha_byte};
      if (voxel_expect.size() == 0) begin
        report_bad("unexpected result", '0, got);
      end else begin
        want = voxel_expect.pop_front();
        if (got.voxel_index !== want.voxel_index || got.blue_byte !== want.blue_byte ||
            got.green_byte !== want.green_byte || got.red_byte !== want.red_byte ||
            got.alpha_byte !== want.alpha_byte) begin
          report_bad("result mismatch", want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------- driving

  // Waits until every pending result is in, then reports anything still pending as a
  // miss and waits on for dropped nodes still in flight.
  task automatic drain_pipe();
    @(negedge clk);
    start <= 1'b0;
    for (int i = 0; i < 300 && voxel_expect.size() != 0; i++) @(posedge clk);
    while (voxel_expect.size() != 0) begin
      report_bad("missing result", voxel_expect.pop_front(), '0);
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(vsq_pkg::vsq_cfg_idx_t which,
                           logic [vsq_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (which)
      vsq_pkg::CFG_RESOLUTION:
        grid_cfg.resolution      = val[vsq_pkg::ResW-1:0];
      vsq_pkg::CFG_EXTENT:
        grid_cfg.extent          = val[vsq_pkg::ExtentW-1:0];
      vsq_pkg::CFG_GRID_SCALE:
        grid_cfg.grid_scale      = val[vsq_pkg::ScaleW-1:0];
      vsq_pkg::CFG_INV_MAX_DENSITY:
        grid_cfg.inv_max_density = val[vsq_pkg::InvW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sender bursts and gaps; now and then it holds off until the pipe is empty
  task automatic pace();
    int gap;
    if ($urandom_range(0, 149) == 0) drain_pipe();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    burst_left--;
  endtask

  task automatic issue_node(node_t n, bit typed, bit typed_hit, voxel_word_t typed_word);
    voxel_word_t w;
    bit          hit;
    @(negedge clk);
    start      <= 1'b1;
    node_valid <= n.node_valid;
    center_x   <= n.center_x;
    center_y   <= n.center_y;
    center_z   <= n.center_z;
    density    <= n.density;
    comp_b     <= n.comp_b;
    comp_g     <= n.comp_g;
    comp_r     <= n.comp_r;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (typed) begin
      hit = typed_hit;
      w   = typed_word;
    end else begin
      hit = splat_node(n, w);
    end
    if (hit) voxel_expect.push_back(w);
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic node_t mk_node(bit v, int x, int y, int z, int d,
                                    shortint b, shortint g, shortint r);
    node_t n;
    n.node_valid = v;
    n.center_x   = x;
    n.center_y   = y;
    n.center_z   = z;
    n.density    = d;
    n.comp_b     = b;
    n.comp_g     = g;
    n.comp_r     = r;
    return n;
  endfunction

  function automatic dir_row_t node_row(node_t n);
    dir_row_t row;
    row = '{write_idx: vsq_pkg::CFG_RESOLUTION, default: '0};
    row.node = n;
    return row;
  endfunction

  function automatic dir_row_t typed_row(node_t n, bit hit, voxel_word_t w);
    dir_row_t row;
    row = node_row(n);
    row.typed      = 1'b1;
    row.typed_hit  = hit;
    row.typed_word = w;
    return row;
  endfunction

  function automatic dir_row_t write_row(vsq_pkg::vsq_cfg_idx_t which,
                                         logic [vsq_pkg::CfgDataW-1:0] val);
    dir_row_t row;
    row = '{write_idx: vsq_pkg::CFG_RESOLUTION, default: '0};
    row.is_write  = 1'b1;
    row.write_idx = which;
    row.write_val = val;
    return row;
  endfunction

  // mostly inside [-span, span], some near the edges, some raw 32-bit
  function automatic int pick_coord(int unsigned span);
    longint c;
    case ($urandom_range(0, 9))
      0: return int'($urandom());
      1: c = longint'(span) + longint'($urandom_range(0, 1024)) - 512;
      2: c = -longint'(span) + longint'($urandom_range(0, 1024)) - 512;
      default: c = longint'($urandom_range(2 * span, 0)) - longint'(span);
    endcase
    if (c > I32_MAX) c = I32_MAX;
    if (c < I32_MIN) c = I32_MIN;
    return int'(c);
  endfunction

  // mostly 0..1.0625, some raw 16-bit
  function automatic logic signed [vsq_pkg::CompW-1:0] pick_comp();
    if ($urandom_range(0, 3) == 0) return vsq_pkg::CompW'($urandom());
    return vsq_pkg::CompW'($urandom_range(0, 17408));
  endfunction

  function automatic node_t random_node(int unsigned span);
    node_t n;
    n.node_valid = ($urandom_range(0, 9) != 0);
    n.center_x   = pick_coord(span);
    n.center_y   = pick_coord(span);
    n.center_z   = pick_coord(span);
    n.density    = ($urandom_range(0, 3) == 0) ? $urandom() :
                   ($urandom() >> $urandom_range(1, 31));
    n.comp_b     = pick_comp();
    n.comp_g     = pick_comp();
    n.comp_r     = pick_comp();
    return n;
  endfunction

  initial begin : stimulus
    dir_row_t    dir_tbl[$];
    node_t       n;
    int unsigned res;
    int unsigned span;
    u64_t        ext;
    u64_t        scale;
    u64_t        inv;
    int          quota;
    int          sent;

    rst        = 1'b1;
    start      = 1'b0;
    node_valid = 1'b0;
    center_x   = '0;
    center_y   = '0;
    center_z   = '0;
    density    = '0;
    comp_b     = '0;
    comp_g     = '0;
    comp_r     = '0;
    cfg_valid  = 1'b0;
    cfg_index  = vsq_pkg::CFG_RESOLUTION;
    cfg_data   = '0;
    grid_cfg.resolution      = vsq_pkg::RES_RESET;
    grid_cfg.extent          = vsq_pkg::EXTENT_RESET;
    grid_cfg.grid_scale      = vsq_pkg::SCALE_RESET;
    grid_cfg.inv_max_density = vsq_pkg::INV_RESET;

    // reset config: R=256, extent 1.0, 128 voxels per unit -> voxel = (c + 1.0) >> 9
    dir_tbl.push_back(typed_row(mk_node(1, 0, 0, 0, ONE_Q16, 16384, 16384, 16384),
                                1, '{24'h808080, 8'd255, 8'd255, 8'd255, 8'd255}));
    dir_tbl.push_back(typed_row(mk_node(0, 0, 0, 0, ONE_Q16, 16384, 16384, 16384), 0, '0));
    dir_tbl.push_back(typed_row(mk_node(1, -ONE_Q16, -ONE_Q16, -ONE_Q16, 0, 0, 0, 0),
                                1, '{24'h0, 8'd0, 8'd0, 8'd0, 8'd0}));
    dir_tbl.push_back(typed_row(mk_node(1, 65535, 65535, 65535, 32'sh7FFF_FFFF,
                                        32767, 32767, 32767),
                                1, '{24'hFFFFFF, 8'd255, 8'd255, 8'd255, 8'd255}));
    dir_tbl.push_back(typed_row(mk_node(1, ONE_Q16, 0, 0, ONE_Q16, 1, 1, 1), 0, '0));
    dir_tbl.push_back(typed_row(mk_node(1, 0, ONE_Q16, 0, ONE_Q16, 1, 1, 1), 0, '0));
    dir_tbl.push_back(typed_row(mk_node(1, 0, 0, ONE_Q16, ONE_Q16, 1, 1, 1), 0, '0));
    // tiny negative sum truncates to voxel 0; one voxel's worth below is dropped
    dir_tbl.push_back(typed_row(mk_node(1, -65537, -ONE_Q16, -ONE_Q16, ONE_Q16, 0, 0, 0),
                                1, '{24'h0, 8'd0, 8'd0, 8'd0, 8'd255}));
    dir_tbl.push_back(typed_row(mk_node(1, -66048, 0, 0, ONE_Q16, 0, 0, 0), 0, '0));
    dir_tbl.push_back(typed_row(mk_node(1, 32'sh8000_0000, 0, 0, ONE_Q16, 0, 0, 0), 0, '0));
    dir_tbl.push_back(typed_row(mk_node(1, 0, 32'sh7FFF_FFFF, 0, ONE_Q16, 0, 0, 0), 0, '0));
    dir_tbl.push_back(typed_row(mk_node(1, 0, 0, 0, 32'sh8000_0000, -32768, -32768, -32768),
                                1, '{24'h808080, 8'd0, 8'd0, 8'd0, 8'd0}));
    dir_tbl.push_back(node_row(mk_node(1, 511, 512, 1000, 32768, 64, 65, 8192)));
    dir_tbl.push_back(node_row(mk_node(1, -33000, 12345, -60000, 1, 16383, 16385, 1)));
    // zero resolution: nothing lands
    dir_tbl.push_back(write_row(vsq_pkg::CFG_RESOLUTION, 40'd0));
    dir_tbl.push_back(typed_row(mk_node(1, 0, 0, 0, ONE_Q16, 1, 1, 1), 0, '0));
    // resolution above 256: index wraps at 24 bits
    dir_tbl.push_back(write_row(vsq_pkg::CFG_RESOLUTION, 40'd511));
    dir_tbl.push_back(write_row(vsq_pkg::CFG_GRID_SCALE, 40'hFF_FFFF_FFFF));
    dir_tbl.push_back(node_row(mk_node(1, 65535, 0, 65000, ONE_Q16, 100, 200, 300)));
    dir_tbl.push_back(node_row(mk_node(1, 65000, 65000, 65000, 98304, 9000, 12000, 15000)));
    // zero scale: every node is voxel 0
    dir_tbl.push_back(write_row(vsq_pkg::CFG_GRID_SCALE, 40'd0));
    dir_tbl.push_back(typed_row(mk_node(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 12345, ONE_Q16,
                                        8192, 8192, 8192),
                                1, '{24'h0, 8'd127, 8'd127, 8'd127, 8'd255}));
    dir_tbl.push_back(write_row(vsq_pkg::CFG_INV_MAX_DENSITY, 40'd0));
    dir_tbl.push_back(typed_row(mk_node(1, 0, 0, 0, 32'sh7FFF_FFFF, 0, 0, 0),
                                1, '{24'h0, 8'd0, 8'd0, 8'd0, 8'd0}));
    dir_tbl.push_back(write_row(vsq_pkg::CFG_INV_MAX_DENSITY, 40'h00_FFFF_FFFF));
    dir_tbl.push_back(node_row(mk_node(1, 0, 0, 0, 1, 0, 0, 0)));
    dir_tbl.push_back(node_row(mk_node(1, 0, 0, 0, 2, 0, 0, 0)));
    dir_tbl.push_back(write_row(vsq_pkg::CFG_EXTENT, 40'h00_7FFF_FFFF));
    dir_tbl.push_back(write_row(vsq_pkg::CFG_GRID_SCALE, 40'd1));
    dir_tbl.push_back(write_row(vsq_pkg::CFG_RESOLUTION, 40'd256));
    dir_tbl.push_back(node_row(mk_node(1, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 40000,
                                       20000, 300, 16384)));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_write) begin
        drain_pipe();
        write_reg(dir_tbl[i].write_idx, dir_tbl[i].write_val);
      end else begin
        pace();
        issue_node(dir_tbl[i].node, dir_tbl[i].typed, dir_tbl[i].typed_hit,
                   dir_tbl[i].typed_word);
      end
    end

    for (int ph = 0; ph < 12; ph++) begin
      res = $urandom_range(1, 256);
      if ($urandom_range(0, 1) == 1) res = 1 << $urandom_range(0, 8);
      // extent at least R*256 keeps the matching scale within 40 bits
      ext   = u64_t'(($urandom() >> $urandom_range(1, 23)) | (res << 8));
      scale = (u64_t'(res) << 47) / ext;
      inv   = u64_t'($urandom() >> $urandom_range(0, 24));
      span  = 32'(ext);
      case (ph)
        1: begin
          res   = 1;
          scale = (u64_t'(1) << 47) / ext;
        end
        2: begin
          res   = 256;
          scale = (u64_t'(256) << 47) / ext;
        end
        3: res = 0;
        4: begin
          res   = 511;
          ext   = u64_t'(ONE_Q16);
          scale = 64'hFF_FFFF_FFFF;
          span  = 32'(ext);
        end
        5: begin
          ext   = 0;
          res   = 64;
          scale = u64_t'(1) << 32;
          span  = 32 << 16;
        end
        6: begin
          ext   = 64'h7FFF_FFFF;
          res   = 256;
          scale = (u64_t'(256) << 47) / ext;
          span  = 32'(ext);
        end
        7: scale = 0;
        8: begin
          res   = 256;
          ext   = 32768;
          scale = 64'hFF_FFFF_FFFF;
          span  = 32'(ext);
        end
        9:  inv = 0;
        10: inv = 64'hFFFF_FFFF;
        default: ;
      endcase
      drain_pipe();
      write_reg(vsq_pkg::CFG_RESOLUTION, vsq_pkg::CfgDataW'(res));
      write_reg(vsq_pkg::CFG_EXTENT, vsq_pkg::CfgDataW'(ext));
      write_reg(vsq_pkg::CFG_GRID_SCALE, vsq_pkg::CfgDataW'(scale));
      write_reg(vsq_pkg::CFG_INV_MAX_DENSITY, vsq_pkg::CfgDataW'(inv));

      quota = (ph == 3) ? 30 : 110;
      sent  = 0;
      while (sent < quota) begin
        n = random_node(span);
        pace();
        issue_node(n, 1'b0, 1'b0, '0);
        if (n.node_valid) sent++;
      end
    end

    drain_pipe();
    if (mismatch_cnt == 0) begin
      $display("voxel_splat_quantizer_tb: PASS");
    end else begin
      $display("voxel_splat_quantizer_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("voxel_splat_quantizer_tb: FAIL");
    $finish;
  end

endmodule
